/* hw/rtl/dhd_pkg.sv */
package dhd_pkg;

    // Table geometry
    localparam int TABLE_SIZE  = 4093;
    localparam int MAX_LETTERS = 12;

    // Field widths
    localparam int LET_W = 24;
    localparam int LEN_W = 4;
    localparam int KEY_W = 28;

    // Derived widths
    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
    localparam int GROUPS = (MAX_LETTERS + 2) / 3;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int IDX_W  = LEN_W + 1;

    // Reciprocals for the two reductions, scaled by 2**KEY_W
    localparam logic [KEY_W-1:0] RECIP_N  = KEY_W'((64'd1 << KEY_W) / TABLE_SIZE);
    localparam logic [KEY_W-1:0] RECIP_N1 = KEY_W'((64'd1 << KEY_W) / (TABLE_SIZE - 1));

    // Operation codes
    localparam logic OP_FIND   = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } key_res_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] pos;
        logic [ADDR_W-1:0] stride;
    } hash_res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

/* hw/rtl/dhd_key_unit.sv */
module dhd_key_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   go,
    input  logic [23:0]            letters,
    input  logic [3:0]             word_length,
    output dhd_pkg::key_res_t      key_res
);
    import dhd_pkg::*;

    logic             active_reg;
    logic             valid_reg;
    logic [GRP_W-1:0] grp_reg;
    logic [LET_W-1:0] letters_reg;
    logic [LEN_W-1:0] len_reg;
    logic [KEY_W-1:0] acc_reg;

    logic [KEY_W-1:0] acc_next;
    logic [6:0]       chunk;
    logic [IDX_W-1:0] base_idx;
    logic [2:0]       digit [3];

    // Weight of a three-letter group: 125 ** g
    function automatic logic [KEY_W-1:0] group_weight(input logic [GRP_W-1:0] g);
        logic [KEY_W-1:0] w;
        logic [KEY_W-1:0] p;
        w = '0;
        p = KEY_W'(1);
        for (int i = 0; i < GROUPS; i++)
        begin
            if (g == GRP_W'(i))
            begin
                w = p;
            end
            p = KEY_W'(p * KEY_W'(125));
        end
        return w;
    endfunction

    always_comb
    begin
        base_idx = IDX_W'(grp_reg) * IDX_W'(3);
        for (int j = 0; j < 3; j++)
        begin
            // letters past the word length contribute nothing
            if ((base_idx + IDX_W'(j)) < IDX_W'(len_reg))
            begin
                digit[j] = {1'b0, letters_reg[2*j +: 2]} + 3'd1;
            end
            else
            begin
                digit[j] = 3'd0;
            end
        end
        chunk    = 7'(digit[0]) + 7'(7'(digit[1]) * 7'd5) + 7'(7'(digit[2]) * 7'd25);
        acc_next = acc_reg + KEY_W'(group_weight(grp_reg) * KEY_W'(chunk));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            grp_reg    <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            if (go)
            begin
                active_reg <= 1'b1;
                grp_reg    <= '0;
            end
            else if (active_reg)
            begin
                grp_reg <= grp_reg + GRP_W'(1);
                if (grp_reg == GRP_W'(GROUPS - 1))
                begin
                    active_reg <= 1'b0;
                    valid_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            letters_reg <= letters;
            // saturate the length
            len_reg     <= (word_length > LEN_W'(MAX_LETTERS)) ? LEN_W'(MAX_LETTERS)
                                                               : word_length;
            acc_reg     <= '0;
        end
        else if (active_reg)
        begin
            letters_reg <= letters_reg >> 6;
            acc_reg     <= acc_next;
        end
    end

    assign key_res.valid = valid_reg;
    assign key_res.key   = acc_reg;

endmodule

/* hw/rtl/dhd_mod_unit.sv */
module dhd_mod_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [27:0]           key,
    output dhd_pkg::hash_res_t    hash_res
);
    import dhd_pkg::*;

    localparam logic [KEY_W-1:0] MOD_A = KEY_W'(TABLE_SIZE);
    localparam logic [KEY_W-1:0] MOD_B = KEY_W'(TABLE_SIZE - 1);

    logic [2:0]         stage_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [2*KEY_W-1:0] prod_a_reg;
    logic [2*KEY_W-1:0] prod_b_reg;
    logic [KEY_W-1:0]   rem_a_reg;
    logic [KEY_W-1:0]   rem_b_reg;
    logic [ADDR_W-1:0]  pos_reg;
    logic [ADDR_W-1:0]  stride_reg;

    logic [KEY_W-1:0]   q_a;
    logic [KEY_W-1:0]   q_b;

    assign q_a = prod_a_reg[2*KEY_W-1:KEY_W];
    assign q_b = prod_b_reg[2*KEY_W-1:KEY_W];

    // Advance a three-stage reduction: estimate quotient, subtract, correct once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= {stage_reg[1:0], go};
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            key_reg    <= key;
            prod_a_reg <= (2*KEY_W)'(key) * (2*KEY_W)'(RECIP_N);
            prod_b_reg <= (2*KEY_W)'(key) * (2*KEY_W)'(RECIP_N1);
        end
        if (stage_reg[0])
        begin
            rem_a_reg <= key_reg - KEY_W'(q_a * MOD_A);
            rem_b_reg <= key_reg - KEY_W'(q_b * MOD_B);
        end
        if (stage_reg[1])
        begin
            pos_reg    <= (rem_a_reg >= MOD_A) ? ADDR_W'(rem_a_reg - MOD_A)
                                               : ADDR_W'(rem_a_reg);
            stride_reg <= (rem_b_reg >= MOD_B) ? ADDR_W'(rem_b_reg - MOD_B + KEY_W'(1))
                                               : ADDR_W'(rem_b_reg + KEY_W'(1));
        end
    end

    assign hash_res.valid  = stage_reg[2];
    assign hash_res.pos    = pos_reg;
    assign hash_res.stride = stride_reg;

endmodule

/* hw/rtl/dhd_slot_ram.sv */
module dhd_slot_ram (
    input  logic                clk,
    input  dhd_pkg::ram_req_t   req,
    output logic [27:0]         rdata
);
    import dhd_pkg::*;

    logic [KEY_W-1:0] mem [TABLE_SIZE];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/double_hash_dictionary_unit.sv */
// Channel   Signals                          Handshake
// -------   ------------------------------   ---------------------------------------
// command   opcode, letters, word_length     word taken when start && !busy
// result    present, table_full              word valid for one cycle while done high
//
// A word with a nonzero key passes through the key build, the two modulo reductions
// and the slot probes in turn, one probe a cycle through the slot RAM read port.
// A word of zero length gives its result straight after the key build, with no probe.
// After reset the block sweeps all TABLE_SIZE slots (4093) clear, one slot a cycle,
// with busy high. The receiver cannot stall: results are never held.
module double_hash_dictionary_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [23:0] letters,
    input  logic [3:0]  word_length,
    output logic        done,
    output logic        present,
    output logic        table_full
);
    import dhd_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_KEY,
        ST_HASH,
        ST_PROBE
    } state_t;

    localparam logic [ADDR_W:0] SIZE_EXT = (ADDR_W + 1)'(TABLE_SIZE);

    state_t            state_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              present_reg;
    logic              full_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              insert_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] stride_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic              accept;
    key_res_t          key_res;
    hash_res_t         hash_res;
    ram_req_t          ram_req;
    logic [KEY_W-1:0]  rdata;
    logic [ADDR_W:0]   pos_sum;
    logic [ADDR_W-1:0] pos_next;
    logic              hit;
    logic              empty;

    assign accept = start && !busy_reg;

    dhd_key_unit u_key (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (accept),
        .letters     (letters),
        .word_length (word_length),
        .key_res     (key_res)
    );

    // Start the reductions only for a nonzero key
    dhd_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (key_res.valid && (key_res.key != '0)),
        .key      (key_res.key),
        .hash_res (hash_res)
    );

    dhd_slot_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    // Next slot of the walk; pos and stride are both below N, so one subtract wraps
    always_comb
    begin
        pos_sum  = {1'b0, pos_reg} + {1'b0, stride_reg};
        pos_next = (pos_sum >= SIZE_EXT) ? ADDR_W'(pos_sum - SIZE_EXT) : ADDR_W'(pos_sum);
        hit      = (rdata == key_reg);
        empty    = (rdata == '0);
    end

    // Drive the RAM: clearing sweep, insert on an empty slot, and the read address
    // one probe ahead so each probe costs a single cycle
    always_comb
    begin
        ram_req.we    = 1'b0;
        ram_req.waddr = pos_reg;
        ram_req.wdata = key_reg;
        ram_req.raddr = pos_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_addr_reg;
                ram_req.wdata = '0;
            end
            ST_HASH:
            begin
                ram_req.raddr = hash_res.pos;
            end
            ST_PROBE:
            begin
                ram_req.raddr = pos_next;
                ram_req.we    = !hit && empty && (insert_reg == OP_INSERT);
            end
            default:
            begin
                ram_req.we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            busy_reg     <= 1'b1;
            done_reg     <= 1'b0;
            present_reg  <= 1'b0;
            full_reg     <= 1'b0;
            clr_addr_reg <= '0;
            insert_reg   <= 1'b0;
            key_reg      <= '0;
            pos_reg      <= '0;
            stride_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == ADDR_W'(TABLE_SIZE - 1))
                    begin
                        busy_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        insert_reg <= opcode;
                        busy_reg   <= 1'b1;
                        state_reg  <= ST_KEY;
                    end
                end
                ST_KEY:
                begin
                    if (key_res.valid)
                    begin
                        key_reg <= key_res.key;
                        if (key_res.key == '0)
                        begin
                            // empty word: nothing to probe
                            present_reg <= 1'b0;
                            full_reg    <= 1'b0;
                            done_reg    <= 1'b1;
                            busy_reg    <= 1'b0;
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_HASH;
                        end
                    end
                end
                ST_HASH:
                begin
                    if (hash_res.valid)
                    begin
                        pos_reg    <= hash_res.pos;
                        stride_reg <= hash_res.stride;
                        cnt_reg    <= '0;
                        state_reg  <= ST_PROBE;
                    end
                end
                ST_PROBE:
                begin
                    if (hit || empty)
                    begin
                        present_reg <= hit;
                        full_reg    <= 1'b0;
                        done_reg    <= 1'b1;
                        busy_reg    <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                    else if (cnt_reg == CNT_W'(TABLE_SIZE - 1))
                    begin
                        // every slot visited: drop the word
                        present_reg <= 1'b0;
                        full_reg    <= 1'b1;
                        done_reg    <= 1'b1;
                        busy_reg    <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        pos_reg <= pos_next;
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign present    = present_reg;
    assign table_full = full_reg;

endmodule

/* hw/rtl/dhd_checker.sv */
module dhd_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic present,
    input logic table_full
);

    // A result word frees the block in the same cycle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // An accepted word makes the block busy on the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // A result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // A result only follows work in progress
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a word in progress");

    // A word cannot be both found and lost to a full table
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(present && table_full))
        else $error("present and table_full together");

endmodule

bind double_hash_dictionary_unit dhd_checker u_dhd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .present    (present),
    .table_full (table_full)
);
